>>> design/calendar_date_arithmetic_top_macros.svh
// Assertion macros shared by the calendar date arithmetic block.
`ifndef CALENDAR_DATE_ARITHMETIC_TOP_MACROS_SVH
`define CALENDAR_DATE_ARITHMETIC_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CDA_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the following cycle.
`define CDA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Invariant checked at every rising clock edge outside reset.
`define CDA_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

`endif

>>> design/cda_pkg.sv
// Types, constants and calendar helper functions of the date arithmetic block.
`default_nettype none
package cda_pkg;

   localparam int YEAR_WIDTH  = 16;
   localparam int COUNT_WIDTH = 15;
   localparam int DAY_WIDTH   = COUNT_WIDTH + 2;

   // Reciprocal of 100 scaled by 2^(YEAR_WIDTH+7); exact for every year of YEAR_WIDTH bits.
   localparam int RECIP_SHIFT  = YEAR_WIDTH + 7;
   localparam int RECIP_WIDTH  = YEAR_WIDTH + 1;
   localparam int RECIP_PROD_W = YEAR_WIDTH + RECIP_WIDTH;
   localparam int QUOT_WIDTH   = YEAR_WIDTH - 6;
   localparam logic [RECIP_WIDTH-1:0] RECIP_100 =
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) / 64'd100) + 64'd1);

   localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};
   localparam logic [YEAR_WIDTH-1:0] YEAR_MIN = YEAR_WIDTH'(1);

   localparam logic [1:0] REQ_SET     = 2'd0;
   localparam logic [1:0] REQ_ADD     = 2'd1;
   localparam logic [1:0] REQ_SUB     = 2'd2;
   localparam logic [1:0] REQ_COMPARE = 2'd3;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] DAYS_31 = 5'd31;
   localparam logic [4:0] DAYS_30 = 5'd30;
   localparam logic [4:0] DAYS_29 = 5'd29;
   localparam logic [4:0] DAYS_28 = 5'd28;

   localparam logic [6:0] MOD100_LAST = 7'd99;

   // Year residue: year mod 100 and (year / 100) mod 4.
   typedef struct packed {
      logic       done;
      logic [6:0] mod100;
      logic [1:0] cent;
   } cda_mod_result_type;

   function automatic logic is_leap(input logic [1:0] low_bits, input logic [6:0] mod100,
                                    input logic [1:0] cent);
      is_leap = (low_bits == 2'd0) && ((mod100 != 7'd0) || (cent == 2'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      len = DAYS_31;
      if (month == MONTH_FEB) begin
         len = leap ? DAYS_29 : DAYS_28;
      end else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
                   (month == MONTH_SEP) || (month == MONTH_NOV)) begin
         len = DAYS_30;
      end
      month_len = len;
   endfunction

endpackage
`default_nettype wire

>>> design/calendar_date_arithmetic_top.sv
// Gregorian date register with set, add days, subtract days and compare requests.
// One request is taken at a time and answered by one result beat. A set passes
// through the reciprocal-multiply unit that finds the new year's remainder modulo
// 100 and its century phase for the leap rule. Add and subtract walk one month per
// cycle through a single add/compare unit.
// A new request is accepted while an earlier result still waits on the output.
`default_nettype none
`include "calendar_date_arithmetic_top_macros.svh"
module calendar_date_arithmetic_top
   import cda_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_type,
   input  wire logic [4:0]             req_given_day,
   input  wire logic [3:0]             req_given_month,
   input  wire logic [YEAR_WIDTH-1:0]  req_given_year,
   input  wire logic [COUNT_WIDTH-1:0] req_day_count,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [4:0]                  rsp_out_day,
   output logic [3:0]                  rsp_out_month,
   output logic [YEAR_WIDTH-1:0]       rsp_out_year,
   output logic                        rsp_leap_year,
   output logic                        rsp_earlier,
   output logic                        rsp_same_day_month,
   output logic                        rsp_same_date,
   output logic                        rsp_range_error
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SET  = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_SUB  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [4:0]                   cur_day_ff, cur_day_in;
   logic [3:0]                   cur_month_ff, cur_month_in;
   logic [YEAR_WIDTH-1:0]        cur_year_ff, cur_year_in;
   logic [6:0]                   cur_mod100_ff, cur_mod100_in;
   logic [1:0]                   cur_cent_ff, cur_cent_in;
   logic signed [DAY_WIDTH-1:0]  wd_ff, wd_in;
   logic [3:0]                   wm_ff, wm_in;
   logic [YEAR_WIDTH-1:0]        wy_ff, wy_in;
   logic [6:0]                   wmod_ff, wmod_in;
   logic [1:0]                   wcent_ff, wcent_in;
   logic                         earlier_ff, earlier_in;
   logic                         same_dm_ff, same_dm_in;
   logic                         same_all_ff, same_all_in;
   logic                         rerr_ff, rerr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [4:0]                   rsp_day_ff, rsp_day_in;
   logic [3:0]                   rsp_month_ff, rsp_month_in;
   logic [YEAR_WIDTH-1:0]        rsp_year_ff, rsp_year_in;
   logic                         rsp_leap_ff, rsp_leap_in;
   logic                         rsp_earlier_ff, rsp_earlier_in;
   logic                         rsp_same_dm_ff, rsp_same_dm_in;
   logic                         rsp_same_all_ff, rsp_same_all_in;
   logic                         rsp_rerr_ff, rsp_rerr_in;

   logic                         accept;
   logic                         mod_start;
   cda_mod_result_type           mod_res;
   logic                         work_leap;
   logic                         set_leap;
   logic [4:0]                   set_lim;
   logic [4:0]                   cur_len;
   logic [4:0]                   prev_len;
   logic signed [DAY_WIDTH-1:0]  cur_len_s;
   logic signed [DAY_WIDTH-1:0]  prev_len_s;
   logic [4:0]                   clamp_day;
   logic [3:0]                   clamp_month;
   logic [YEAR_WIDTH-1:0]        clamp_year;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign mod_start = accept && (req_type == REQ_SET);

   cda_year_mod u_year_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .year   (clamp_year),
      .result (mod_res)
   );

   always_comb begin
      clamp_day   = (req_given_day == 5'd0) ? 5'd1 : req_given_day;
      clamp_month = (req_given_month == 4'd0) ? MONTH_JAN :
                    ((req_given_month > MONTH_DEC) ? MONTH_DEC : req_given_month);
      clamp_year  = (req_given_year == '0) ? YEAR_MIN : req_given_year;
   end

   // The shared step unit: length of the working month and of the month before it, and the set day limit.
   always_comb begin
      work_leap  = is_leap(wy_ff[1:0], wmod_ff, wcent_ff);
      cur_len    = month_len(wm_ff, work_leap);
      prev_len   = (wm_ff == MONTH_JAN) ? DAYS_31 : month_len(wm_ff - 4'd1, work_leap);
      cur_len_s  = signed'({{(DAY_WIDTH-5){1'b0}}, cur_len});
      prev_len_s = signed'({{(DAY_WIDTH-5){1'b0}}, prev_len});
      set_leap   = is_leap(wy_ff[1:0], mod_res.mod100, mod_res.cent);
      set_lim    = month_len(wm_ff, set_leap);
   end

   always_comb begin
      state_in        = state_ff;
      cur_day_in      = cur_day_ff;
      cur_month_in    = cur_month_ff;
      cur_year_in     = cur_year_ff;
      cur_mod100_in   = cur_mod100_ff;
      cur_cent_in     = cur_cent_ff;
      wd_in           = wd_ff;
      wm_in           = wm_ff;
      wy_in           = wy_ff;
      wmod_in         = wmod_ff;
      wcent_in        = wcent_ff;
      earlier_in      = earlier_ff;
      same_dm_in      = same_dm_ff;
      same_all_in     = same_all_ff;
      rerr_in         = rerr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_day_in      = rsp_day_ff;
      rsp_month_in    = rsp_month_ff;
      rsp_year_in     = rsp_year_ff;
      rsp_leap_in     = rsp_leap_ff;
      rsp_earlier_in  = rsp_earlier_ff;
      rsp_same_dm_in  = rsp_same_dm_ff;
      rsp_same_all_in = rsp_same_all_ff;
      rsp_rerr_in     = rsp_rerr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               earlier_in  = 1'b0;
               same_dm_in  = 1'b0;
               same_all_in = 1'b0;
               rerr_in     = 1'b0;
               wm_in       = cur_month_ff;
               wy_in       = cur_year_ff;
               wmod_in     = cur_mod100_ff;
               wcent_in    = cur_cent_ff;
               unique case (req_type)
                  REQ_SET: begin
                     wd_in    = DAY_WIDTH'(clamp_day);
                     wm_in    = clamp_month;
                     wy_in    = clamp_year;
                     state_in = ST_SET;
                  end
                  REQ_ADD: begin
                     wd_in    = DAY_WIDTH'(cur_day_ff) + DAY_WIDTH'(req_day_count);
                     state_in = ST_ADD;
                  end
                  REQ_SUB: begin
                     wd_in    = DAY_WIDTH'(cur_day_ff) - DAY_WIDTH'(req_day_count);
                     state_in = ST_SUB;
                  end
                  REQ_COMPARE: begin
                     same_dm_in  = (cur_day_ff == req_given_day) &&
                                   (cur_month_ff == req_given_month);
                     same_all_in = same_dm_in && (cur_year_ff == req_given_year);
                     earlier_in  = (cur_year_ff < req_given_year) ||
                                   ((cur_year_ff == req_given_year) &&
                                    ((cur_month_ff < req_given_month) ||
                                     ((cur_month_ff == req_given_month) &&
                                      (cur_day_ff < req_given_day))));
                     state_in    = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SET: begin
            if (mod_res.done) begin
               cur_day_in    = (wd_ff[4:0] > set_lim) ? set_lim : wd_ff[4:0];
               cur_month_in  = wm_ff;
               cur_year_in   = wy_ff;
               cur_mod100_in = mod_res.mod100;
               cur_cent_in   = mod_res.cent;
               state_in      = ST_DONE;
            end
         end
         ST_ADD: begin
            if (wd_ff > cur_len_s) begin
               if (wm_ff == MONTH_DEC) begin
                  if (wy_ff == YEAR_MAX) begin
                     rerr_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     wd_in = wd_ff - cur_len_s;
                     wm_in = MONTH_JAN;
                     wy_in = wy_ff + 1'b1;
                     if (wmod_ff == MOD100_LAST) begin
                        wmod_in  = '0;
                        wcent_in = wcent_ff + 1'b1;
                     end else begin
                        wmod_in = wmod_ff + 1'b1;
                     end
                  end
               end else begin
                  wd_in = wd_ff - cur_len_s;
                  wm_in = wm_ff + 4'd1;
               end
            end else begin
               cur_day_in    = wd_ff[4:0];
               cur_month_in  = wm_ff;
               cur_year_in   = wy_ff;
               cur_mod100_in = wmod_ff;
               cur_cent_in   = wcent_ff;
               state_in      = ST_DONE;
            end
         end
         ST_SUB: begin
            if (wd_ff <= 0) begin
               if (wm_ff == MONTH_JAN) begin
                  if (wy_ff == YEAR_MIN) begin
                     rerr_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     // December is 31 days whatever the year.
                     wd_in = wd_ff + prev_len_s;
                     wm_in = MONTH_DEC;
                     wy_in = wy_ff - 1'b1;
                     if (wmod_ff == '0) begin
                        wmod_in  = MOD100_LAST;
                        wcent_in = wcent_ff - 1'b1;
                     end else begin
                        wmod_in = wmod_ff - 1'b1;
                     end
                  end
               end else begin
                  wd_in = wd_ff + prev_len_s;
                  wm_in = wm_ff - 4'd1;
               end
            end else begin
               cur_day_in    = wd_ff[4:0];
               cur_month_in  = wm_ff;
               cur_year_in   = wy_ff;
               cur_mod100_in = wmod_ff;
               cur_cent_in   = wcent_ff;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_day_in      = cur_day_ff;
               rsp_month_in    = cur_month_ff;
               rsp_year_in     = cur_year_ff;
               rsp_leap_in     = is_leap(cur_year_ff[1:0], cur_mod100_ff, cur_cent_ff);
               rsp_earlier_in  = earlier_ff;
               rsp_same_dm_in  = same_dm_ff;
               rsp_same_all_in = same_all_ff;
               rsp_rerr_in     = rerr_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_day_ff    <= 5'd1;
         cur_month_ff  <= MONTH_JAN;
         cur_year_ff   <= YEAR_MIN;
         cur_mod100_ff <= 7'd1;
         cur_cent_ff   <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_day_ff    <= cur_day_in;
         cur_month_ff  <= cur_month_in;
         cur_year_ff   <= cur_year_in;
         cur_mod100_ff <= cur_mod100_in;
         cur_cent_ff   <= cur_cent_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      wd_ff           <= wd_in;
      wm_ff           <= wm_in;
      wy_ff           <= wy_in;
      wmod_ff         <= wmod_in;
      wcent_ff        <= wcent_in;
      earlier_ff      <= earlier_in;
      same_dm_ff      <= same_dm_in;
      same_all_ff     <= same_all_in;
      rerr_ff         <= rerr_in;
      rsp_day_ff      <= rsp_day_in;
      rsp_month_ff    <= rsp_month_in;
      rsp_year_ff     <= rsp_year_in;
      rsp_leap_ff     <= rsp_leap_in;
      rsp_earlier_ff  <= rsp_earlier_in;
      rsp_same_dm_ff  <= rsp_same_dm_in;
      rsp_same_all_ff <= rsp_same_all_in;
      rsp_rerr_ff     <= rsp_rerr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_day        = rsp_day_ff;
   assign rsp_out_month      = rsp_month_ff;
   assign rsp_out_year       = rsp_year_ff;
   assign rsp_leap_year      = rsp_leap_ff;
   assign rsp_earlier        = rsp_earlier_ff;
   assign rsp_same_day_month = rsp_same_dm_ff;
   assign rsp_same_date      = rsp_same_all_ff;
   assign rsp_range_error    = rsp_rerr_ff;

   `CDA_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready)
   `CDA_ASSERT_ALWAYS(a_date_legal, (cur_day_ff != 5'd0) && (cur_month_ff != 4'd0) &&
      (cur_month_ff <= MONTH_DEC) && (cur_year_ff != '0))
   `CDA_ASSERT_IMPLIES(a_error_not_compare, rsp_valid, !(rsp_range_error &&
      (rsp_earlier || rsp_same_day_month)))
   `CDA_ASSERT_IMPLIES(a_same_date_implies_dm, rsp_valid && rsp_same_date, rsp_same_day_month)

endmodule
`default_nettype wire

>>> design/cda_year_mod.sv
// Reduction of a year into year mod 100 and its century phase by reciprocal multiply.
`default_nettype none
module cda_year_mod
   import cda_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [YEAR_WIDTH-1:0] year,
   output cda_mod_result_type         result
);

   localparam logic [YEAR_WIDTH-1:0] CENTURY = YEAR_WIDTH'(100);

   logic                    stage_ff, stage_in;
   logic                    done_ff, done_in;
   logic [YEAR_WIDTH-1:0]   year_ff, year_in;
   logic [QUOT_WIDTH-1:0]   quot_ff, quot_in;
   logic [6:0]              mod100_ff, mod100_in;
   logic [1:0]              cent_ff, cent_in;
   logic [RECIP_PROD_W-1:0] product;
   logic [YEAR_WIDTH-1:0]   hundreds;
   logic [6:0]              rest;

   // The quotient year / 100 is registered first, then the remainder and the century phase from it.
   always_comb begin
      product   = RECIP_PROD_W'(year) * RECIP_PROD_W'(RECIP_100);
      hundreds  = YEAR_WIDTH'(quot_ff) * CENTURY;
      rest      = 7'(year_ff - hundreds);
      stage_in  = start;
      done_in   = stage_ff;
      year_in   = start ? year : year_ff;
      quot_in   = start ? product[RECIP_PROD_W-1:RECIP_SHIFT] : quot_ff;
      mod100_in = stage_ff ? rest : mod100_ff;
      cent_in   = stage_ff ? quot_ff[1:0] : cent_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      year_ff   <= year_in;
      quot_ff   <= quot_in;
      mod100_ff <= mod100_in;
      cent_ff   <= cent_in;
   end

   always_comb begin
      result.done   = done_ff;
      result.mod100 = mod100_ff;
      result.cent   = cent_ff;
   end

endmodule
`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the calendar date arithmetic block.
`timescale 1ns / 100ps
module tb
   import cda_pkg::*;
();

   localparam int RUN_LIMIT  = 3_000_000;
   localparam int LONG_HOLD  = 400;
   localparam int SETTLE     = 30;
   localparam int N_DIRECTED = 25;

   typedef struct packed {
      logic [4:0]            day;
      logic [3:0]            month;
      logic [YEAR_WIDTH-1:0] year;
      logic                  leap;
      logic                  earlier;
      logic                  same_dm;
      logic                  same_all;
      logic                  range_err;
   } date_result_type;

   typedef struct {
      logic [1:0]             kind;
      logic [4:0]             day;
      logic [3:0]             month;
      logic [YEAR_WIDTH-1:0]  year;
      logic [COUNT_WIDTH-1:0] count;
      bit                     typed;
      date_result_type        want;
   } stim_row_type;

   localparam date_result_type UNTYPED = '0;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_type = REQ_SET;
   logic [4:0]             req_given_day = '0;
   logic [3:0]             req_given_month = '0;
   logic [YEAR_WIDTH-1:0]  req_given_year = '0;
   logic [COUNT_WIDTH-1:0] req_day_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [4:0]             rsp_out_day;
   logic [3:0]             rsp_out_month;
   logic [YEAR_WIDTH-1:0]  rsp_out_year;
   logic                   rsp_leap_year;
   logic                   rsp_earlier;
   logic                   rsp_same_day_month;
   logic                   rsp_same_date;
   logic                   rsp_range_error;

   // Predicted calendar state.
   logic [4:0]             cal_day = 5'd1;
   logic [3:0]             cal_month = MONTH_JAN;
   logic [YEAR_WIDTH-1:0]  cal_year = YEAR_MIN;

   date_result_type expected_dates [$];
   date_result_type want_date;
   int              mismatch_count = 0;
   int unsigned     cycle_count = 0;
   int              send_idle_pct = 23;
   int              recv_idle_pct = 77;
   int              hold_requests = 0;
   int              holds_served = 0;
   int              hold_left = 0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{REQ_COMPARE, 5'd1, 4'd1, 16'd1, 15'd0, 1'b1,
        '{5'd1, 4'd1, 16'd1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{REQ_SUB, 5'd0, 4'd0, 16'd0, 15'd1, 1'b1,
        '{5'd1, 4'd1, 16'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{REQ_SET, 5'd0, 4'd0, 16'd0, 15'd0, 1'b1,
        '{5'd1, 4'd1, 16'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_SET, 5'd31, 4'd15, YEAR_MAX, 15'd0, 1'b1,
        '{5'd31, 4'd12, YEAR_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_ADD, 5'd0, 4'd0, 16'd0, 15'd1, 1'b1,
        '{5'd31, 4'd12, YEAR_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{REQ_ADD, 5'd0, 4'd0, 16'd0, 15'd0, 1'b1,
        '{5'd31, 4'd12, YEAR_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_COMPARE, 5'd31, 4'd12, YEAR_MAX, 15'd0, 1'b1,
        '{5'd31, 4'd12, YEAR_MAX, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{REQ_COMPARE, 5'd31, 4'd15, YEAR_MAX, 15'd0, 1'b1,
        '{5'd31, 4'd12, YEAR_MAX, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{REQ_SET, 5'd31, 4'd2, 16'd2000, 15'd0, 1'b1,
        '{5'd29, 4'd2, 16'd2000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_ADD, 5'd0, 4'd0, 16'd0, 15'd1, 1'b0, UNTYPED},
      '{REQ_SET, 5'd31, 4'd2, 16'd1900, 15'd0, 1'b1,
        '{5'd28, 4'd2, 16'd1900, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_SET, 5'd29, 4'd2, 16'd2024, 15'd0, 1'b1,
        '{5'd29, 4'd2, 16'd2024, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_SET, 5'd31, 4'd4, 16'd2023, 15'd0, 1'b1,
        '{5'd30, 4'd4, 16'd2023, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_ADD, 5'd0, 4'd0, 16'd0, 15'h7fff, 1'b0, UNTYPED},
      '{REQ_SUB, 5'd0, 4'd0, 16'd0, 15'h7fff, 1'b0, UNTYPED},
      '{REQ_SET, 5'd1, 4'd3, 16'd2023, 15'd0, 1'b1,
        '{5'd1, 4'd3, 16'd2023, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_SUB, 5'd0, 4'd0, 16'd0, 15'd1, 1'b1,
        '{5'd28, 4'd2, 16'd2023, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_SET, 5'd1, 4'd1, 16'd2, 15'd0, 1'b1,
        '{5'd1, 4'd1, 16'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_SUB, 5'd0, 4'd0, 16'd0, 15'd1, 1'b1,
        '{5'd31, 4'd12, 16'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_SUB, 5'd0, 4'd0, 16'd0, 15'd365, 1'b0, UNTYPED},
      '{REQ_SET, 5'd15, 4'd6, YEAR_MAX, 15'd0, 1'b1,
        '{5'd15, 4'd6, YEAR_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_ADD, 5'd0, 4'd0, 16'd0, 15'd200, 1'b0, UNTYPED},
      '{REQ_SET, 5'd31, 4'd1, 16'd2100, 15'd0, 1'b1,
        '{5'd31, 4'd1, 16'd2100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{REQ_ADD, 5'd0, 4'd0, 16'd0, 15'd29, 1'b0, UNTYPED},
      '{REQ_COMPARE, 5'd1, 4'd3, 16'd2100, 15'd0, 1'b0, UNTYPED}
   };

   calendar_date_arithmetic_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_given_day      (req_given_day),
      .req_given_month    (req_given_month),
      .req_given_year     (req_given_year),
      .req_day_count      (req_day_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_day        (rsp_out_day),
      .rsp_out_month      (rsp_out_month),
      .rsp_out_year       (rsp_out_year),
      .rsp_leap_year      (rsp_leap_year),
      .rsp_earlier        (rsp_earlier),
      .rsp_same_day_month (rsp_same_day_month),
      .rsp_same_date      (rsp_same_date),
      .rsp_range_error    (rsp_range_error)
   );

   always #5 clock = ~clock;

   function automatic bit leap_of(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in(input int m, input int y);
      case (4'(m))
         MONTH_FEB: return leap_of(y) ? int'(DAYS_29) : int'(DAYS_28);
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return int'(DAYS_30);
         default: return int'(DAYS_31);
      endcase
   endfunction

   // Applies one request to the predicted date and returns the result beat it causes.
   function automatic date_result_type predict_date_result(input logic [1:0] kind,
         input logic [4:0] gd, input logic [3:0] gm, input logic [YEAR_WIDTH-1:0] gy,
         input logic [COUNT_WIDTH-1:0] cnt);
      date_result_type res;
      int              d;
      int              m;
      int              y;
      bit              bad;
      res = '0;
      bad = 1'b0;
      d = int'(cal_day);
      m = int'(cal_month);
      y = int'(cal_year);
      case (kind)
         REQ_SET: begin
            d = (gd == 5'd0) ? 1 : int'(gd);
            m = (gm == 4'd0) ? int'(MONTH_JAN) : (gm > MONTH_DEC) ? int'(MONTH_DEC) : int'(gm);
            y = (gy == '0) ? 1 : int'(gy);
            if (d > days_in(m, y)) begin
               d = days_in(m, y);
            end
         end
         REQ_ADD: begin
            d = d + int'(cnt);
            while (!bad && d > days_in(m, y)) begin
               d = d - days_in(m, y);
               m = m + 1;
               if (m > int'(MONTH_DEC)) begin
                  m = int'(MONTH_JAN);
                  if (y >= int'(YEAR_MAX)) bad = 1'b1;
                  else y = y + 1;
               end
            end
         end
         REQ_SUB: begin
            d = d - int'(cnt);
            while (!bad && d <= 0) begin
               if (m <= int'(MONTH_JAN)) begin
                  if (y <= 1) begin
                     bad = 1'b1;
                  end else begin
                     y = y - 1;
                     m = int'(MONTH_DEC);
                  end
               end else begin
                  m = m - 1;
               end
               if (!bad) d = d + days_in(m, y);
            end
         end
         default: begin
            // Given fields are taken raw, with no clamping.
            if (cal_year < gy) begin
               res.earlier = 1'b1;
            end else if (cal_year == gy) begin
               res.earlier = (cal_month < gm) || ((cal_month == gm) && (cal_day < gd));
            end
            res.same_dm = (cal_day == gd) && (cal_month == gm);
            res.same_all = res.same_dm && (cal_year == gy);
         end
      endcase
      if (kind != REQ_COMPARE && !bad) begin
         cal_day = 5'(d);
         cal_month = 4'(m);
         cal_year = YEAR_WIDTH'(y);
      end
      res.range_err = bad;
      res.day = cal_day;
      res.month = cal_month;
      res.year = cal_year;
      res.leap = leap_of(int'(cal_year));
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   // Offers one request beat, holds it until taken and records what it should produce.
   task automatic send_request(input stim_row_type row);
      date_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_type = row.kind;
      req_given_day = row.day;
      req_given_month = row.month;
      req_given_year = row.year;
      req_day_count = row.count;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predicted = predict_date_result(row.kind, row.day, row.month, row.year, row.count);
      expected_dates.push_back(row.typed ? row.want : predicted);
      @(negedge clock);
   endtask

   task automatic wait_all_answered();
      req_valid = 1'b0;
      while (expected_dates.size() != 0) @(negedge clock);
   endtask

   task automatic run_random(input int n);
      stim_row_type row;
      int           pick;
      for (int i = 0; i < n; i++) begin
         row.typed = 1'b0;
         row.want = UNTYPED;
         pick = $urandom_range(99);
         row.kind = (pick < 25) ? REQ_SET : (pick < 55) ? REQ_ADD :
                    (pick < 85) ? REQ_SUB : REQ_COMPARE;
         row.day = 5'($urandom_range(31));
         row.month = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(12, 1));
         // Years lean toward both ends of the range and toward century years.
         pick = $urandom_range(99);
         if (pick < 20) row.year = YEAR_MAX - YEAR_WIDTH'($urandom_range(3));
         else if (pick < 35) row.year = YEAR_WIDTH'($urandom_range(3));
         else if (pick < 50) row.year = YEAR_WIDTH'($urandom_range(163) * 400 +
                                                     $urandom_range(3) * 100);
         else row.year = YEAR_WIDTH'($urandom);
         // Most counts stay short so that the month walk stays quick.
         pick = $urandom_range(99);
         row.count = (pick < 70) ? COUNT_WIDTH'($urandom_range(400)) :
                     (pick < 92) ? COUNT_WIDTH'($urandom_range(4000)) : COUNT_WIDTH'($urandom);
         if (row.kind == REQ_COMPARE && $urandom_range(1) == 1) begin
            // Aim close to the stored date so that the equality flags fire.
            row.day = cal_day + 5'($urandom_range(2)) - 5'd1;
            row.month = ($urandom_range(3) == 0) ? cal_month + 4'd1 : cal_month;
            row.year = ($urandom_range(3) == 0) ? cal_year - 1'b1 : cal_year;
         end
         send_request(row);
      end
   endtask

   // Receiver side: random back-pressure plus a long hold-off when the stimulus asks for one.
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_dates.size() == 0) begin
            report_mismatch("result beat with nothing pending, day", 0, rsp_out_day);
         end else begin
            want_date = expected_dates.pop_front();
            if (rsp_out_day !== want_date.day)
               report_mismatch("day", want_date.day, rsp_out_day);
            if (rsp_out_month !== want_date.month)
               report_mismatch("month", want_date.month, rsp_out_month);
            if (rsp_out_year !== want_date.year)
               report_mismatch("year", want_date.year, rsp_out_year);
            if (rsp_leap_year !== want_date.leap)
               report_mismatch("leap_year", want_date.leap, rsp_leap_year);
            if (rsp_earlier !== want_date.earlier)
               report_mismatch("earlier", want_date.earlier, rsp_earlier);
            if (rsp_same_day_month !== want_date.same_dm)
               report_mismatch("same_day_month", want_date.same_dm, rsp_same_day_month);
            if (rsp_same_date !== want_date.same_all)
               report_mismatch("same_date", want_date.same_all, rsp_same_date);
            if (rsp_range_error !== want_date.range_err)
               report_mismatch("range_error", want_date.range_err, rsp_range_error);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_request(directed_rows[i]);
      end

      run_random(60);
      // The receiver stops for a long while; the sender keeps pushing until it stalls.
      hold_requests++;
      run_random(120);
      wait_all_answered();

      send_idle_pct = 77;
      recv_idle_pct = 23;
      run_random(180);
      wait_all_answered();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(180);
      wait_all_answered();

      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/cda_pkg.sv
design/cda_year_mod.sv
design/calendar_date_arithmetic_top.sv
sim/tb.sv
